>>> hw/rtl/coordinate_system_converter_defines.svh
// ---------------------------------------------------------------------------
// Coordinate system converter assertion macros
// Concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef COORDINATE_SYSTEM_CONVERTER_DEFINES_SVH
`define COORDINATE_SYSTEM_CONVERTER_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csc assertion failed");
// next-cycle implication
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csc assertion failed");
`else
`define CSC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/csc_pkg.sv
// ---------------------------------------------------------------------------
// Coordinate system converter package
// Shared constants, action codes and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package csc_pkg;

    localparam int COORD_WIDTH_DEF     = 32;
    localparam int ROTATION_STAGES_DEF = 24;
    localparam int GUARD_BITS          = 8;
    localparam int ANGLE_WIDTH         = 32;
    localparam int Z_WIDTH             = 34;
    localparam int GAIN_WIDTH          = 30;
    localparam int ATAN_LEN            = 40;

    localparam logic [GAIN_WIDTH-1:0] GAIN_Q30 = 30'd652032874;

    localparam logic [1:0] ACT_CYL2CART = 2'd0;
    localparam logic [1:0] ACT_SPH2CART = 2'd1;
    localparam logic [1:0] ACT_CART2CYL = 2'd2;
    localparam logic [1:0] ACT_CART2SPH = 2'd3;

    localparam logic [29:0] ATAN_TABLE [0:ATAN_LEN-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
        30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
        30'd20, 30'd10, 30'd5, 30'd3, 30'd1,
        30'd1, 30'd0, 30'd0, 30'd0, 30'd0,
        30'd0, 30'd0, 30'd0, 30'd0, 30'd0
    };

    // arctangent of 2^-idx in binary angle units, zero past the table
    function automatic logic signed [Z_WIDTH-1:0] csc_atan(input int idx);
        logic [5:0] sel;
        sel = idx[5:0];
        if (idx >= 0 && idx < ATAN_LEN)
            return $signed({{(Z_WIDTH-30){1'b0}}, ATAN_TABLE[sel]});
        return '0;
    endfunction

endpackage

>>> hw/rtl/coordinate_system_converter.sv
// ---------------------------------------------------------------------------
// Coordinate system converter
// Pipelined CORDIC conversion between Cartesian, cylindrical and spherical.
// ---------------------------------------------------------------------------
// The block takes one request per cycle while in_stall is low and returns one
// result per request, in order. A request passes 2*ROTATION_STAGES+7 registers:
// an input stage, a chain of ROTATION_STAGES CORDIC cells, a gain multiply, a
// second setup stage, a second cell chain and gain multiply, and the output
// register. Every stage holds its request on its own, so empty slots close up
// while the output is stalled; in_stall follows out_stall only once every stage
// is full. Lengths are signed fixed point, angles are binary angles with pi at
// the sign bit; lengths saturate and set saturated, angles wrap.
`include "coordinate_system_converter_defines.svh"

module coordinate_system_converter #(
    parameter int COORD_WIDTH     = csc_pkg::COORD_WIDTH_DEF,
    parameter int ROTATION_STAGES = csc_pkg::ROTATION_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic signed [COORD_WIDTH-1:0] coord_a,
    input  logic signed [COORD_WIDTH-1:0] coord_b,
    input  logic signed [COORD_WIDTH-1:0] coord_c,
    input  logic signed [COORD_WIDTH-1:0] offset_x,
    input  logic signed [COORD_WIDTH-1:0] offset_y,
    input  logic signed [COORD_WIDTH-1:0] offset_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] result_a,
    output logic signed [COORD_WIDTH-1:0] result_b,
    output logic signed [COORD_WIDTH-1:0] result_c,
    output logic                          saturated
);

    localparam int CW  = COORD_WIDTH;
    localparam int N   = ROTATION_STAGES;
    localparam int GB  = csc_pkg::GUARD_BITS;
    localparam int AW  = csc_pkg::ANGLE_WIDTH;
    localparam int ZW  = csc_pkg::Z_WIDTH;
    localparam int W   = CW + GB + 4;
    localparam int S1  = 3 + AW + 4 * CW;
    localparam int S2  = 3 + 2 * W + AW + 4 * CW;
    localparam int GS1 = ZW + S1;
    localparam int GS2 = ZW + S2;

    localparam logic signed [ZW-1:0] HALF_PI = $signed({{(ZW-31){1'b0}}, 1'b1, 30'd0});
    localparam logic signed [ZW-1:0] PI_Z    = $signed({{(ZW-32){1'b0}}, 1'b1, 31'd0});
    localparam logic [AW:0] ANG_RND = (CW < AW) ? (33'd1 << ((CW < AW) ? (31 - CW) : 0))
                                                : 33'd0;

    // top AW bits of a coordinate as a binary angle
    function automatic logic [AW-1:0] angle_in(input logic [CW-1:0] v);
        logic [CW+AW-1:0] t;
        t = {v, {AW{1'b0}}};
        return t[CW+AW-1 -: AW];
    endfunction

    // binary angle scaled to the coordinate width, rounded when narrower
    function automatic logic [CW-1:0] angle_out(input logic [AW-1:0] a);
        logic [AW:0]      r;
        logic [CW+AW-1:0] t;
        r = {1'b0, a} + ANG_RND;
        t = {r[AW-1:0], {CW{1'b0}}};
        return t[CW+AW-1 -: CW];
    endfunction

    // coordinate lengthened by the guard bits
    function automatic logic signed [W-1:0] guard(input logic signed [CW-1:0] v);
        return $signed({{4{v[CW-1]}}, v, {GB{1'b0}}});
    endfunction

    // drop guard bits with round half up
    function automatic logic signed [W:0] unguard(input logic signed [W-1:0] v);
        logic signed [W:0] t;
        t = $signed({v[W-1], v}) + $signed({{(W+1-GB){1'b0}}, 1'b1, {(GB-1){1'b0}}});
        return t >>> GB;
    endfunction

    function automatic logic signed [W+1:0] add_off(input logic signed [W:0] u,
                                                    input logic signed [CW-1:0] o);
        return $signed({u[W], u}) + $signed({{(W+2-CW){o[CW-1]}}, o});
    endfunction

    // clip to the coordinate range, flag in the top bit
    function automatic logic [CW:0] sat_fn(input logic signed [W+1:0] v);
        logic signed [W+1:0] hi, lo;
        hi = $signed({{(W+3-CW){1'b0}}, {(CW-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
            return {1'b1, hi[CW-1:0]};
        else if (v < lo)
            return {1'b1, lo[CW-1:0]};
        return {1'b0, v[CW-1:0]};
    endfunction

    // -----------------------------------------------------------------------
    // input setup stage: scale, fold the angle or the vector
    // -----------------------------------------------------------------------
    logic                 s0_v_reg, s0_ready;
    logic                 s0_vec_reg;
    logic signed [W-1:0]  s0_x_reg, s0_y_reg, s0_x_next, s0_y_next;
    logic signed [ZW-1:0] s0_z_reg, s0_z_next;
    logic [S1-1:0]        s0_side_reg, s0_side_next;
    logic signed [ZW-1:0] zin;
    logic [AW-1:0]        ang_rot, phi_in;
    logic                 zero1;

    always_comb
    begin
        ang_rot = angle_in((action == csc_pkg::ACT_CYL2CART) ? coord_b : coord_c);
        phi_in  = angle_in(coord_b);
        zin     = $signed({{(ZW-AW){ang_rot[AW-1]}}, ang_rot});
        zero1   = (coord_a == '0) && (coord_b == '0);
        s0_x_next = guard(coord_a);
        s0_y_next = '0;
        s0_z_next = zin;
        if (!action[1])
        begin
            if (zin > HALF_PI)
            begin
                s0_x_next = -guard(coord_a);
                s0_z_next = zin - PI_Z;
            end
            else if (zin < -HALF_PI)
            begin
                s0_x_next = -guard(coord_a);
                s0_z_next = zin + PI_Z;
            end
        end
        else
        begin
            s0_y_next = guard(coord_b);
            s0_z_next = '0;
            if (coord_a[CW-1])
            begin
                s0_x_next = -guard(coord_a);
                s0_y_next = -guard(coord_b);
                s0_z_next = PI_Z;
            end
        end
        s0_side_next = {action, zero1, phi_in, coord_c, offset_x, offset_y, offset_z};
    end

    logic p1_ready0;

    assign s0_ready = ~s0_v_reg | p1_ready0;
    assign in_stall = ~s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (s0_ready)
            s0_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_vec_reg  <= action[1];
            s0_x_reg    <= s0_x_next;
            s0_y_reg    <= s0_y_next;
            s0_z_reg    <= s0_z_next;
            s0_side_reg <= s0_side_next;
        end
    end

    // -----------------------------------------------------------------------
    // first CORDIC chain
    // -----------------------------------------------------------------------
    logic                 p1_v   [0:N];
    logic                 p1_rdy [0:N];
    logic                 p1_vec [0:N];
    logic signed [W-1:0]  p1_x   [0:N];
    logic signed [W-1:0]  p1_y   [0:N];
    logic signed [ZW-1:0] p1_z   [0:N];
    logic [S1-1:0]        p1_side[0:N];

    assign p1_v[0]    = s0_v_reg;
    assign p1_vec[0]  = s0_vec_reg;
    assign p1_x[0]    = s0_x_reg;
    assign p1_y[0]    = s0_y_reg;
    assign p1_z[0]    = s0_z_reg;
    assign p1_side[0] = s0_side_reg;
    assign p1_ready0  = p1_rdy[0];

    for (genvar i = 0; i < N; i++)
    begin : g_pass1
        csc_cell #(.STAGE(i), .W(W), .SW(S1)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (p1_v[i]),
            .up_ready (p1_rdy[i]),
            .up_vec   (p1_vec[i]),
            .up_x     (p1_x[i]),
            .up_y     (p1_y[i]),
            .up_z     (p1_z[i]),
            .up_side  (p1_side[i]),
            .dn_valid (p1_v[i+1]),
            .dn_ready (p1_rdy[i+1]),
            .dn_vec   (p1_vec[i+1]),
            .dn_x     (p1_x[i+1]),
            .dn_y     (p1_y[i+1]),
            .dn_z     (p1_z[i+1]),
            .dn_side  (p1_side[i+1])
        );
    end

    // -----------------------------------------------------------------------
    // first gain correction
    // -----------------------------------------------------------------------
    logic                g1_v, g1_rdy;
    logic signed [W-1:0] g1_x, g1_y;
    logic [GS1-1:0]      g1_side;
    logic                s2_ready;

    csc_gain #(.W(W), .SW(GS1)) u_gain1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (p1_v[N]),
        .up_ready (p1_rdy[N]),
        .up_x     (p1_x[N]),
        .up_y     (p1_y[N]),
        .up_side  ({p1_z[N], p1_side[N]}),
        .dn_valid (g1_v),
        .dn_ready (g1_rdy),
        .dn_x     (g1_x),
        .dn_y     (g1_y),
        .dn_side  (g1_side)
    );

    assign g1_rdy = s2_ready;

    // -----------------------------------------------------------------------
    // second setup stage
    // -----------------------------------------------------------------------
    logic [1:0]           g1_action;
    logic                 g1_zero;
    logic [AW-1:0]        g1_phi_in;
    logic signed [ZW-1:0] g1_z;
    logic [4*CW-1:0]      g1_pass;
    logic signed [CW-1:0] g1_c;
    logic signed [W-1:0]  mag1;
    logic [AW-1:0]        phi1;
    logic signed [ZW-1:0] zphi;
    logic                 zero2;
    logic                 s2_v_reg, s2_vec_reg;
    logic signed [W-1:0]  s2_x_reg, s2_y_reg, s2_x_next, s2_y_next;
    logic signed [ZW-1:0] s2_z_reg, s2_z_next;
    logic [S2-1:0]        s2_side_reg, s2_side_next;

    assign g1_z      = g1_side[GS1-1 -: ZW];
    assign g1_action = g1_side[S1-1 -: 2];
    assign g1_zero   = g1_side[S1-3];
    assign g1_phi_in = g1_side[S1-4 -: AW];
    assign g1_pass   = g1_side[4*CW-1:0];
    assign g1_c      = g1_side[4*CW-1 -: CW];

    always_comb
    begin
        mag1  = g1_zero ? '0 : g1_x;
        phi1  = g1_zero ? '0 : g1_z[AW-1:0];
        zphi  = $signed({{(ZW-AW){g1_phi_in[AW-1]}}, g1_phi_in});
        zero2 = (g1_c == '0) && (mag1 == '0);
        s2_x_next = '0;
        s2_y_next = '0;
        s2_z_next = '0;
        case (g1_action)
            csc_pkg::ACT_SPH2CART:
            begin
                s2_x_next = g1_y;
                s2_z_next = zphi;
                if (zphi > HALF_PI)
                begin
                    s2_x_next = -g1_y;
                    s2_z_next = zphi - PI_Z;
                end
                else if (zphi < -HALF_PI)
                begin
                    s2_x_next = -g1_y;
                    s2_z_next = zphi + PI_Z;
                end
            end
            csc_pkg::ACT_CART2SPH:
            begin
                s2_x_next = guard(g1_c);
                s2_y_next = mag1;
                if (g1_c[CW-1])
                begin
                    s2_x_next = -guard(g1_c);
                    s2_y_next = -mag1;
                    s2_z_next = PI_Z;
                end
            end
            default:
            begin
                s2_x_next = '0;
            end
        endcase
        s2_side_next = {g1_action, zero2, (g1_action[1] ? mag1 : g1_x), g1_y, phi1, g1_pass};
    end

    logic p2_ready0;

    assign s2_ready = ~s2_v_reg | p2_ready0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (s2_ready)
            s2_v_reg <= g1_v;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && g1_v)
        begin
            s2_vec_reg  <= g1_action[1];
            s2_x_reg    <= s2_x_next;
            s2_y_reg    <= s2_y_next;
            s2_z_reg    <= s2_z_next;
            s2_side_reg <= s2_side_next;
        end
    end

    // -----------------------------------------------------------------------
    // second CORDIC chain
    // -----------------------------------------------------------------------
    logic                 p2_v   [0:N];
    logic                 p2_rdy [0:N];
    logic                 p2_vec [0:N];
    logic signed [W-1:0]  p2_x   [0:N];
    logic signed [W-1:0]  p2_y   [0:N];
    logic signed [ZW-1:0] p2_z   [0:N];
    logic [S2-1:0]        p2_side[0:N];

    assign p2_v[0]    = s2_v_reg;
    assign p2_vec[0]  = s2_vec_reg;
    assign p2_x[0]    = s2_x_reg;
    assign p2_y[0]    = s2_y_reg;
    assign p2_z[0]    = s2_z_reg;
    assign p2_side[0] = s2_side_reg;
    assign p2_ready0  = p2_rdy[0];

    for (genvar i = 0; i < N; i++)
    begin : g_pass2
        csc_cell #(.STAGE(i), .W(W), .SW(S2)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (p2_v[i]),
            .up_ready (p2_rdy[i]),
            .up_vec   (p2_vec[i]),
            .up_x     (p2_x[i]),
            .up_y     (p2_y[i]),
            .up_z     (p2_z[i]),
            .up_side  (p2_side[i]),
            .dn_valid (p2_v[i+1]),
            .dn_ready (p2_rdy[i+1]),
            .dn_vec   (p2_vec[i+1]),
            .dn_x     (p2_x[i+1]),
            .dn_y     (p2_y[i+1]),
            .dn_z     (p2_z[i+1]),
            .dn_side  (p2_side[i+1])
        );
    end

    // -----------------------------------------------------------------------
    // second gain correction
    // -----------------------------------------------------------------------
    logic                g2_v, g2_rdy;
    logic signed [W-1:0] g2_x, g2_y;
    logic [GS2-1:0]      g2_side;

    csc_gain #(.W(W), .SW(GS2)) u_gain2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (p2_v[N]),
        .up_ready (p2_rdy[N]),
        .up_x     (p2_x[N]),
        .up_y     (p2_y[N]),
        .up_side  ({p2_z[N], p2_side[N]}),
        .dn_valid (g2_v),
        .dn_ready (g2_rdy),
        .dn_x     (g2_x),
        .dn_y     (g2_y),
        .dn_side  (g2_side)
    );

    // -----------------------------------------------------------------------
    // output stage: unguard, offset, saturate
    // -----------------------------------------------------------------------
    logic signed [ZW-1:0] f_z;
    logic [1:0]           f_action;
    logic                 f_zero;
    logic signed [W-1:0]  f_r1, f_r2, mag3;
    logic [AW-1:0]        f_phi, theta;
    logic signed [CW-1:0] f_c, f_ox, f_oy, f_oz;
    logic [CW:0]          sa, sb, sc;
    logic signed [CW-1:0] ra_next, rb_next, rc_next;
    logic                 sat_next;
    logic                 out_valid_reg;
    logic signed [CW-1:0] ra_reg, rb_reg, rc_reg;
    logic                 sat_reg;

    assign f_z      = g2_side[GS2-1 -: ZW];
    assign f_action = g2_side[S2-1 -: 2];
    assign f_zero   = g2_side[S2-3];
    assign f_r1     = g2_side[S2-4 -: W];
    assign f_r2     = g2_side[S2-4-W -: W];
    assign f_phi    = g2_side[4*CW+AW-1 -: AW];
    assign f_c      = g2_side[4*CW-1 -: CW];
    assign f_ox     = g2_side[3*CW-1 -: CW];
    assign f_oy     = g2_side[2*CW-1 -: CW];
    assign f_oz     = g2_side[CW-1:0];

    always_comb
    begin
        mag3  = f_zero ? '0 : g2_x;
        theta = f_zero ? '0 : f_z[AW-1:0];
        sa = '0;
        sb = '0;
        sc = '0;
        ra_next = '0;
        rb_next = '0;
        rc_next = '0;
        case (f_action)
            csc_pkg::ACT_CYL2CART:
            begin
                sa = sat_fn(add_off(unguard(f_r1), f_ox));
                sb = sat_fn(add_off(unguard(f_r2), f_oy));
                ra_next = sa[CW-1:0];
                rb_next = sb[CW-1:0];
                rc_next = f_c;
            end
            csc_pkg::ACT_SPH2CART:
            begin
                sa = sat_fn(add_off(unguard(g2_x), f_ox));
                sb = sat_fn(add_off(unguard(g2_y), f_oy));
                sc = sat_fn(add_off(unguard(f_r1), f_oz));
                ra_next = sa[CW-1:0];
                rb_next = sb[CW-1:0];
                rc_next = sc[CW-1:0];
            end
            csc_pkg::ACT_CART2CYL:
            begin
                sa = sat_fn(add_off(unguard(f_r1), '0));
                ra_next = sa[CW-1:0];
                rb_next = angle_out(f_phi);
                rc_next = f_c;
            end
            default:
            begin
                sa = sat_fn(add_off(unguard(mag3), '0));
                ra_next = sa[CW-1:0];
                rb_next = angle_out(f_phi);
                rc_next = angle_out(theta);
            end
        endcase
        sat_next = sa[CW] | sb[CW] | sc[CW];
    end

    assign g2_rdy = ~out_valid_reg | ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (g2_rdy)
            out_valid_reg <= g2_v;
    end

    always_ff @(posedge clk)
    begin
        if (g2_rdy && g2_v)
        begin
            ra_reg  <= ra_next;
            rb_reg  <= rb_next;
            rc_reg  <= rc_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_a  = ra_reg;
    assign result_b  = rb_reg;
    assign result_c  = rc_reg;
    assign saturated = sat_reg;

    // -----------------------------------------------------------------------
    // assertions
    // -----------------------------------------------------------------------
    `CSC_ASSERT_IMPL(a_stall_means_full, clk, rst_n, in_stall, out_valid && out_stall)
    `CSC_ASSERT_NEXT(a_accept_loads_setup, clk, rst_n, in_valid && !in_stall, s0_v_reg)
    `CSC_ASSERT_IMPL(a_fold_range, clk, rst_n, s0_v_reg && !s0_vec_reg,
                     (s0_z_reg <= HALF_PI) && (s0_z_reg >= -HALF_PI))

endmodule

>>> hw/rtl/csc_cell.sv
// ---------------------------------------------------------------------------
// CORDIC micro-rotation cell
// One registered rotation or vectoring step with a fixed shift.
// ---------------------------------------------------------------------------
module csc_cell #(
    parameter int STAGE = 0,
    parameter int W     = 44,
    parameter int SW    = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  logic                               up_vec,
    input  logic signed [W-1:0]                up_x,
    input  logic signed [W-1:0]                up_y,
    input  logic signed [csc_pkg::Z_WIDTH-1:0] up_z,
    input  logic [SW-1:0]                      up_side,
    output logic                               dn_valid,
    input  logic                               dn_ready,
    output logic                               dn_vec,
    output logic signed [W-1:0]                dn_x,
    output logic signed [W-1:0]                dn_y,
    output logic signed [csc_pkg::Z_WIDTH-1:0] dn_z,
    output logic [SW-1:0]                      dn_side
);

    localparam logic signed [csc_pkg::Z_WIDTH-1:0] ATAN = csc_pkg::csc_atan(STAGE);

    logic                               valid_reg;
    logic                               vec_reg;
    logic signed [W-1:0]                x_reg, x_next;
    logic signed [W-1:0]                y_reg, y_next;
    logic signed [csc_pkg::Z_WIDTH-1:0] z_reg, z_next;
    logic [SW-1:0]                      side_reg;
    logic signed [W-1:0]                dx, dy;
    logic                               dir, sub;

    // pick rotation direction from angle or from y sign
    always_comb
    begin
        dx  = up_y >>> STAGE;
        dy  = up_x >>> STAGE;
        dir = up_vec ? ~up_y[W-1] : ~up_z[csc_pkg::Z_WIDTH-1];
        sub = (dir != up_vec);
        if (sub)
        begin
            x_next = up_x - dx;
            y_next = up_y + dy;
            z_next = up_z - ATAN;
        end
        else
        begin
            x_next = up_x + dx;
            y_next = up_y - dy;
            z_next = up_z + ATAN;
        end
    end

    assign up_ready = ~valid_reg | dn_ready;

    // advance the request when this cell is empty or the next cell can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            vec_reg  <= up_vec;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_vec   = vec_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_z     = z_reg;
    assign dn_side  = side_reg;

endmodule

>>> hw/rtl/csc_gain.sv
// ---------------------------------------------------------------------------
// CORDIC gain correction
// Two-stage multiply of x and y by the Q30 gain with round half up.
// ---------------------------------------------------------------------------
module csc_gain #(
    parameter int W  = 44,
    parameter int SW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  logic signed [W-1:0] up_x,
    input  logic signed [W-1:0] up_y,
    input  logic [SW-1:0]       up_side,
    output logic                dn_valid,
    input  logic                dn_ready,
    output logic signed [W-1:0] dn_x,
    output logic signed [W-1:0] dn_y,
    output logic [SW-1:0]       dn_side
);

    localparam int GW = csc_pkg::GAIN_WIDTH;
    localparam int L  = W / 2;
    localparam int H  = W - L;
    localparam int SUMW = W + 32;
    localparam logic signed [GW:0] GAIN_S = $signed({1'b0, csc_pkg::GAIN_Q30});
    localparam logic signed [SUMW-1:0] ROUND = $signed({{(SUMW-30){1'b0}}, 1'b1, 29'd0});

    logic                  v1_reg, v2_reg;
    logic                  rdy1, rdy2;
    logic signed [H+GW:0]  phx_reg, phy_reg;
    logic [L+GW-1:0]       plx_reg, ply_reg;
    logic [SW-1:0]         side1_reg, side2_reg;
    logic signed [W-1:0]   x_reg, y_reg;
    logic signed [SUMW-1:0] sumx, sumy;

    assign rdy2     = ~v2_reg | dn_ready;
    assign rdy1     = ~v1_reg | rdy2;
    assign up_ready = rdy1;

    // recombine partial products and drop the Q30 scale
    always_comb
    begin
        sumx = ($signed({{(L+1){phx_reg[H+GW]}}, phx_reg}) <<< L)
             + $signed({{(H+2){1'b0}}, plx_reg}) + ROUND;
        sumy = ($signed({{(L+1){phy_reg[H+GW]}}, phy_reg}) <<< L)
             + $signed({{(H+2){1'b0}}, ply_reg}) + ROUND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= up_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    // split each operand into high signed and low unsigned halves
    always_ff @(posedge clk)
    begin
        if (rdy1 && up_valid)
        begin
            phx_reg   <= $signed(up_x[W-1:L]) * GAIN_S;
            phy_reg   <= $signed(up_y[W-1:L]) * GAIN_S;
            plx_reg   <= up_x[L-1:0] * csc_pkg::GAIN_Q30;
            ply_reg   <= up_y[L-1:0] * csc_pkg::GAIN_Q30;
            side1_reg <= up_side;
        end
        if (rdy2 && v1_reg)
        begin
            x_reg     <= sumx[W+29:30];
            y_reg     <= sumy[W+29:30];
            side2_reg <= side1_reg;
        end
    end

    assign dn_valid = v2_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_side  = side2_reg;

endmodule

>>> sim/coordinate_system_converter_tb.sv
// ---------------------------------------------------------------------------
// Coordinate system converter testbench
// Streams coordinate requests through the converter and checks each result
// against a bit-accurate CORDIC predictor. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
module coordinate_system_converter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES      = 24;
    localparam int RANDOM_REQS = 1080;
    localparam int SETTLE      = 80;

    typedef struct packed {
        logic [1:0]         act;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
    } request_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic        sat;
    } coords_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic signed [31:0] coord_c;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result_a;
    logic signed [31:0] result_b;
    logic signed [31:0] result_c;
    logic               saturated;

    request_t pending_q[$];
    coords_t  expected_q[$];
    int       total_reqs;
    int       accepted_cnt;
    int       issued_cnt;
    int       mismatch_cnt;
    bit       hold_off;

    coordinate_system_converter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .coord_a   (coord_a),
        .coord_b   (coord_b),
        .coord_c   (coord_c),
        .offset_x  (offset_x),
        .offset_y  (offset_y),
        .offset_z  (offset_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result_a  (result_a),
        .result_b  (result_b),
        .result_c  (result_c),
        .saturated (saturated)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // remove CORDIC gain, rounded half up
    function automatic longint drop_gain(input longint v);
        longint hi;
        longint lo;
        longint k;
        k  = longint'({34'b0, csc_pkg::GAIN_Q30});
        hi = v >>> 30;
        lo = v - (hi <<< 30);
        return hi * k + ((lo * k + (64'sd1 <<< 29)) >>> 30);
    endfunction

    function automatic longint unguard(input longint v);
        return (v + (64'sd1 <<< (csc_pkg::GUARD_BITS - 1))) >>> csc_pkg::GUARD_BITS;
    endfunction

    function automatic logic [31:0] clip(input longint v, inout bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // rotate (r, 0) by a binary angle
    function automatic void rotate_len(input longint r, input logic [31:0] ang,
                                       output longint cx, output longint sy);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        z = ang[31] ? longint'({32'b0, ang}) - (64'sd1 <<< 32) : longint'({32'b0, ang});
        x = r;
        y = 0;
        if (z > (64'sd1 <<< 30))
        begin
            x = -x;
            z = z - (64'sd1 <<< 31);
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            x = -x;
            z = z + (64'sd1 <<< 31);
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'({34'b0, csc_pkg::ATAN_TABLE[i]});
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'({34'b0, csc_pkg::ATAN_TABLE[i]});
            end
        end
        cx = drop_gain(x);
        sy = drop_gain(y);
    endfunction

    // length and angle of (x, y)
    function automatic void measure_vec(input longint xi, input longint yi,
                                        output longint mag, output logic [31:0] ang);
        longint x;
        longint y;
        longint dx;
        longint dy;
        logic [63:0] acc;
        x   = xi;
        y   = yi;
        acc = '0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            ang = '0;
            return;
        end
        if (x < 0)
        begin
            x   = -x;
            y   = -y;
            acc = 64'h80000000;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x   = x + dx;
                y   = y - dy;
                acc = acc + {34'b0, csc_pkg::ATAN_TABLE[i]};
            end
            else
            begin
                x   = x - dx;
                y   = y + dy;
                acc = acc - {34'b0, csc_pkg::ATAN_TABLE[i]};
            end
        end
        mag = drop_gain(x);
        ang = acc[31:0];
    endfunction

    function automatic coords_t convert(input request_t r);
        coords_t     e;
        bit          flag;
        longint      g;
        longint      x;
        longint      y;
        longint      zz;
        longint      mag;
        longint      mag3;
        logic [31:0] phi;
        logic [31:0] theta;
        flag = 1'b0;
        g    = 64'sd1 <<< csc_pkg::GUARD_BITS;
        case (r.act)
            csc_pkg::ACT_CYL2CART:
            begin
                rotate_len(longint'(r.a) * g, r.b, x, y);
                e.a = clip(unguard(x) + longint'(r.ox), flag);
                e.b = clip(unguard(y) + longint'(r.oy), flag);
                e.c = r.c;
            end
            csc_pkg::ACT_SPH2CART:
            begin
                rotate_len(longint'(r.a) * g, r.c, zz, mag);
                rotate_len(mag, r.b, x, y);
                e.a = clip(unguard(x) + longint'(r.ox), flag);
                e.b = clip(unguard(y) + longint'(r.oy), flag);
                e.c = clip(unguard(zz) + longint'(r.oz), flag);
            end
            csc_pkg::ACT_CART2CYL:
            begin
                measure_vec(longint'(r.a) * g, longint'(r.b) * g, mag, phi);
                e.a = clip(unguard(mag), flag);
                e.b = phi;
                e.c = r.c;
            end
            default:
            begin
                measure_vec(longint'(r.a) * g, longint'(r.b) * g, mag, phi);
                measure_vec(longint'(r.c) * g, mag, mag3, theta);
                e.a = clip(unguard(mag3), flag);
                e.b = phi;
                e.c = theta;
            end
        endcase
        e.sat = flag;
        return e;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
            2:       return $urandom >>> $urandom_range(0, 31);
            default: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
        endcase
    endfunction

    // idle percentages per phase: receiver first, then sender, then none
    function automatic int idle_pct(input bit rx);
        if (accepted_cnt < total_reqs / 3)
            return rx ? 80 : 32;
        if (accepted_cnt < 2 * total_reqs / 3)
            return rx ? 32 : 80;
        return 0;
    endfunction

    // drive requests at the falling edge, hold while stalled
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || accepted_cnt == issued_cnt))
        begin
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0))
            begin
                in_valid <= 1'b1;
                action   <= pending_q[0].act;
                coord_a  <= pending_q[0].a;
                coord_b  <= pending_q[0].b;
                coord_c  <= pending_q[0].c;
                offset_x <= pending_q[0].ox;
                offset_y <= pending_q[0].oy;
                offset_z <= pending_q[0].oz;
                void'(pending_q.pop_front());
                issued_cnt <= issued_cnt + 1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= hold_off || ($urandom_range(0, 99) < idle_pct(1'b1));
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        hold_off = 1'b0;
        wait (accepted_cnt >= 2 * total_reqs / 3 + 20);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    // accept requests and check results at the rising edge
    always @(posedge clk)
    begin
        coords_t exp_r;
        request_t r;
        if (rst_n && in_valid && !in_stall)
        begin
            r = '{action, coord_a, coord_b, coord_c, offset_x, offset_y, offset_z};
            expected_q.push_back(convert(r));
            accepted_cnt <= accepted_cnt + 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10)
                    $display("unexpected result %h %h %h %b",
                             result_a, result_b, result_c, saturated);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (exp_r.a !== result_a || exp_r.b !== result_b ||
                    exp_r.c !== result_c || exp_r.sat !== saturated)
                begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                                 exp_r.a, exp_r.b, exp_r.c, exp_r.sat,
                                 result_a, result_b, result_c, saturated);
                end
            end
        end
    end

    initial
    begin
        request_t r;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        action       = csc_pkg::ACT_CYL2CART;
        coord_a      = '0;
        coord_b      = '0;
        coord_c      = '0;
        offset_x     = '0;
        offset_y     = '0;
        offset_z     = '0;
        accepted_cnt = 0;
        issued_cnt   = 0;
        mismatch_cnt = 0;

        // directed: zero vectors, pi angles, negative radius, extremes, overflow
        pending_q.push_back('{csc_pkg::ACT_CYL2CART, 32'sh0, 32'sh0, 32'sh0,
                              32'sh0, 32'sh0, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_CYL2CART, 32'sh10000, 32'sh80000000, 32'sh7fffffff,
                              32'sh0, 32'sh0, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_CYL2CART, 32'sh7fffffff, 32'sh0, 32'sh80000000,
                              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
        pending_q.push_back('{csc_pkg::ACT_CYL2CART, 32'sh80000000, 32'sh40000000, 32'sh1,
                              32'sh0, 32'sh7fffffff, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_CYL2CART, -32'sh30000, 32'sh20000000, 32'sh0,
                              32'sh10000, 32'sh10000, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_SPH2CART, 32'sh0, 32'sh0, 32'sh0,
                              32'sh0, 32'sh0, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_SPH2CART, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                              32'sh0, 32'sh0, 32'sh7fffffff});
        pending_q.push_back('{csc_pkg::ACT_SPH2CART, 32'sh80000000, 32'sh40000000, 32'shc0000000,
                              32'sh80000000, 32'sh80000000, 32'sh80000000});
        pending_q.push_back('{csc_pkg::ACT_SPH2CART, -32'sh50000, 32'sh7fffffff, 32'sh20000000,
                              32'sh0, 32'sh0, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_SPH2CART, 32'sh10000, 32'sh0, 32'sh0,
                              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
        pending_q.push_back('{csc_pkg::ACT_CART2CYL, 32'sh0, 32'sh0, 32'sh7fffffff,
                              32'sh0, 32'sh0, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_CART2CYL, -32'sh10000, 32'sh0, 32'sh80000000,
                              32'sh0, 32'sh0, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_CART2CYL, 32'sh7fffffff, 32'sh7fffffff, 32'sh0,
                              32'sh0, 32'sh0, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_CART2CYL, 32'sh80000000, 32'sh80000000, 32'sh1,
                              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
        pending_q.push_back('{csc_pkg::ACT_CART2CYL, 32'sh0, -32'sh1, 32'sh0,
                              32'sh0, 32'sh0, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_CART2SPH, 32'sh0, 32'sh0, 32'sh0,
                              32'sh0, 32'sh0, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_CART2SPH, 32'sh0, 32'sh0, -32'sh10000,
                              32'sh0, 32'sh0, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_CART2SPH, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                              32'sh0, 32'sh0, 32'sh0});
        pending_q.push_back('{csc_pkg::ACT_CART2SPH, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                              32'sh80000000, 32'sh80000000, 32'sh80000000});
        pending_q.push_back('{csc_pkg::ACT_CART2SPH, -32'sh10000, 32'sh0, 32'sh0,
                              32'sh0, 32'sh0, 32'sh0});

        // random requests with mixed magnitudes
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            r.act = 2'($urandom_range(0, 3));
            r.a   = rand_coord();
            r.b   = rand_coord();
            r.c   = rand_coord();
            r.ox  = rand_coord();
            r.oy  = rand_coord();
            r.oz  = rand_coord();
            pending_q.push_back(r);
        end
        total_reqs = pending_q.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (accepted_cnt == total_reqs && expected_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("coordinate_system_converter test passed");
        else
            $display("coordinate_system_converter test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #(12ns * 200000);
        $display("coordinate_system_converter test failed");
        $finish;
    end

endmodule
